[rtl/one_pole_lowpass_highpass_filter_assert.svh]
// assertion helpers shared by the filter rtl
`ifndef ONE_POLE_LOWPASS_HIGHPASS_FILTER_ASSERT_SVH
`define ONE_POLE_LOWPASS_HIGHPASS_FILTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define OLHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define OLHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/olhp_pkg.sv]
package olhp_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_CUTOFF = 2'd1;
  localparam logic [1:0] CFG_RATE   = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int CUT_W      = 13;
  localparam int RATE_W     = 18;
  localparam int DEN_W      = 19;
  localparam int REM_W      = 20;
  localparam int ALPHA_W    = 16;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = 4;

  localparam logic [CUT_W-1:0]  CUT_MIN   = 13'd50;
  localparam logic [CUT_W-1:0]  CUT_MAX   = 13'd8000;
  localparam logic [CUT_W-1:0]  CUT_RST   = 13'd1000;
  localparam logic [RATE_W-1:0] RATE_RST  = 18'd44100;

  localparam logic MODE_LOWPASS  = 1'b0;
  localparam logic MODE_HIGHPASS = 1'b1;

  // datapath operations
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DIV,
    OP_DIFF,
    OP_MUL,
    OP_SUM,
    OP_PUT
  } op_t;

  // what a step waits on before it jumps to its target
  typedef enum logic [1:0] {
    W_NONE,
    W_INPUT,
    W_LOOP,
    W_OUTPUT
  } wait_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIFF,
    S_MUL,
    S_SUM,
    S_PUT
  } step_t;

  typedef struct packed {
    op_t   op;
    wait_t wt;
    step_t target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic fire;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    case (s)
      S_IDLE:  w = '{op: OP_LOAD, wt: W_INPUT,  target: S_DIV};
      S_DIV:   w = '{op: OP_DIV,  wt: W_LOOP,   target: S_DIFF};
      S_DIFF:  w = '{op: OP_DIFF, wt: W_NONE,   target: S_MUL};
      S_MUL:   w = '{op: OP_MUL,  wt: W_NONE,   target: S_SUM};
      S_SUM:   w = '{op: OP_SUM,  wt: W_NONE,   target: S_PUT};
      S_PUT:   w = '{op: OP_PUT,  wt: W_OUTPUT, target: S_IDLE};
      default: w = '{op: OP_LOAD, wt: W_INPUT,  target: S_DIV};
    endcase
    return w;
  endfunction

endpackage

[rtl/olhp_seq.sv]
module olhp_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_free,
  output olhp_pkg::ctrl_t ctrl
);
  import olhp_pkg::*;

  step_t                pc, pc_next;
  logic [DIV_CNT_W-1:0] cnt, cnt_next;
  ucode_t               word;
  logic                 last;

  assign word = ucode_rom(pc);
  assign last = (cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // control outputs
  always_comb begin
    ctrl.op = word.op;
    case (word.wt)
      W_INPUT:  ctrl.fire = in_valid;
      W_OUTPUT: ctrl.fire = out_free;
      default:  ctrl.fire = 1'b1;
    endcase
  end

  // next step and loop count
  always_comb begin
    pc_next  = pc;
    cnt_next = '0;
    case (word.wt)
      W_LOOP: begin
        if (last) begin
          pc_next = word.target;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      W_INPUT: begin
        if (in_valid) pc_next = word.target;
      end
      W_OUTPUT: begin
        if (out_free) pc_next = word.target;
      end
      default: pc_next = word.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= S_IDLE;
      cnt <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
    end
  end

endmodule

[rtl/one_pole_lowpass_highpass_filter.sv]
// first-order iir low-pass / high-pass filter, one sample per transfer
// input channel: in_valid / in_stall with sample_in and channel; a transfer
//   happens when in_valid is high and in_stall is low
// output channel: out_valid / out_stall with sample_out, held while stalled
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 filter_mode (write clears history), 1 cutoff_hz (clamped
//   to 50..8000), 2 sample_rate_hz, other indexes are dropped
// config is taken only while idle, and a pending write holds the input off
// steps: after the load step come 16 steps of the shared restoring divider
//   that makes alpha, then difference, multiply, sum/saturate and
//   write-back steps
// overlap: a new item is not taken while the last one is in its steps, but as
//   soon as the write-back step has parked its result in the output register,
//   even while that result still waits
// stall: a busy output register holds the sequencer in its write-back step
// reset: registers return to low-pass, 1000 Hz, 44100 Hz, history zero;
//   no transfer is taken on the input or config channel while in reset
module one_pole_lowpass_highpass_filter #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  input  logic                                 channel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        sample_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [olhp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [olhp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import olhp_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration registers
  logic              filter_mode;
  logic [CUT_W-1:0]  cutoff_hz;
  logic [RATE_W-1:0] sample_rate_hz;

  // per-channel history
  logic signed [SB-1:0] last_output [CHANNELS];
  logic signed [SB-1:0] last_input  [CHANNELS];

  // datapath registers
  logic signed [SB-1:0]   x;
  logic [CH_W-1:0]        ch;
  logic [DEN_W-1:0]       den;
  logic [REM_W-1:0]       rem;
  logic [ALPHA_W-1:0]     quo;
  logic                   sat_flag;
  logic [ALPHA_W-1:0]     alpha;
  logic signed [SB+1:0]   diff;
  logic signed [SB+18:0]  prod;
  logic signed [SB-1:0]   y;

  ctrl_t ctrl;
  logic  out_free;
  logic  cfg_we;
  logic  clear_hist;

  olhp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid && !in_stall),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign in_stall  = rst || cfg_valid || (ctrl.op != OP_LOAD);
  assign cfg_ready = !rst && (ctrl.op == OP_LOAD);
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;
  assign clear_hist = cfg_we && (cfg_index == CFG_MODE);

  // cutoff clamp on write
  logic [CUT_W-1:0] cut_wr;
  always_comb begin
    cut_wr = cfg_data[CUT_W-1:0];
    if (cut_wr < CUT_MIN) cut_wr = CUT_MIN;
    if (cut_wr > CUT_MAX) cut_wr = CUT_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode    <= MODE_LOWPASS;
      cutoff_hz      <= CUT_RST;
      sample_rate_hz <= RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   filter_mode    <= cfg_data[0];
        CFG_CUTOFF: cutoff_hz      <= cut_wr;
        CFG_RATE:   sample_rate_hz <= cfg_data[RATE_W-1:0];
        default:    ;
      endcase
    end
  end

  // coefficient numerator: fs for low-pass, fc for high-pass
  logic [DEN_W-1:0] num;
  logic [DEN_W-1:0] den_ld;
  assign num    = (filter_mode == MODE_HIGHPASS) ? DEN_W'(cutoff_hz) : DEN_W'(sample_rate_hz);
  assign den_ld = DEN_W'(cutoff_hz) + DEN_W'(sample_rate_hz);

  // one restoring division step
  logic [REM_W-1:0] rem2;
  logic             ge;
  assign rem2 = {rem[REM_W-2:0], 1'b0};
  assign ge   = (rem2 >= REM_W'(den));

  // history read for the current channel
  logic signed [SB-1:0] yp, xp;
  assign yp = last_output[ch];
  assign xp = last_input[ch];

  logic signed [SB+1:0] diff_next;
  always_comb begin
    if (filter_mode == MODE_HIGHPASS) begin
      diff_next = (SB+2)'(yp) + (SB+2)'(x) - (SB+2)'(xp);
    end else begin
      diff_next = (SB+2)'(yp) - (SB+2)'(x);
    end
  end

  // low-pass folds to x + a*(yprev - x)/65536, high-pass adds nothing
  logic signed [SB+3:0] base;
  logic signed [SB+3:0] sum;
  logic signed [SB-1:0] y_next;
  assign base = (filter_mode == MODE_HIGHPASS) ? (SB+4)'(0) : (SB+4)'(x);
  assign sum  = base + (SB+4)'($signed(prod[SB+18:16]));

  always_comb begin
    if (sum[SB+3:SB-1] == '0 || sum[SB+3:SB-1] == '1) begin
      y_next = sum[SB-1:0];
    end else if (sum[SB+3]) begin
      y_next = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_next = {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.fire) begin
          x        <= sample_in;
          ch       <= (CHANNELS > 1) ? CH_W'(channel) : CH_W'(0);
          den      <= den_ld;
          rem      <= REM_W'(num);
          quo      <= '0;
          // only a zero sample rate in high-pass mode gets here
          sat_flag <= (num >= den_ld);
        end
      end
      OP_DIV: begin
        rem <= ge ? (rem2 - REM_W'(den)) : rem2;
        quo <= {quo[ALPHA_W-2:0], ge};
      end
      OP_DIFF: begin
        diff  <= diff_next;
        alpha <= sat_flag ? '1 : quo;
      end
      OP_MUL: prod <= $signed({1'b0, alpha}) * diff;
      OP_SUM: y <= y_next;
      default: ;
    endcase
  end

  // history write-back and clear
  always_ff @(posedge clk) begin
    if (rst || clear_hist) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_output[i] <= '0;
        last_input[i]  <= '0;
      end
    end else if (ctrl.op == OP_PUT && ctrl.fire) begin
      last_output[ch] <= y;
      last_input[ch]  <= x;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_PUT && ctrl.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_PUT && ctrl.fire) begin
      sample_out <= y;
    end
  end

`include "one_pole_lowpass_highpass_filter_assert.svh"

  `OLHP_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken while busy")
  `OLHP_ASSERT_NEXT(a_put_shows, ctrl.op == OP_PUT && ctrl.fire, out_valid, "result lost")
  `OLHP_ASSERT_NOW(a_sat_hp_only, ctrl.op == OP_DIFF && sat_flag, filter_mode == MODE_HIGHPASS, "lp clamp")

endmodule
